[rtl/asrc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asrc_pkg
// Types and constants shared by the sample rate converter modules.
// ----------------------------------------------------------------------------
package asrc_pkg;

  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned STEP_W      = 13;
  localparam int unsigned OUT_COUNT_W = 24;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned RES_CNT_W   = 7;

  localparam logic [STEP_W-1:0]      STEP_RESET  = 13'd256;
  localparam logic [RES_CNT_W-1:0]   RES_CNT_MAX = 7'd64;
  localparam logic [7:0]             NARROW_BIAS = 8'h80;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_FRAC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_IS_WIDE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_IS_WIDE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT   = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_raw;
    logic                first_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       last_out;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0]      step_frac;
    logic                   in_is_wide;
    logic                   out_is_wide;
    logic [OUT_COUNT_W-1:0] out_count;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic emit;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
    logic out_free;
  } dp_status_t;

endpackage : asrc_pkg
`default_nettype wire

[rtl/asrc_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asrc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module asrc_cfg
  import asrc_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEP_FRAC:   cfg_d.step_frac   = cfg_data_i[STEP_W-1:0];
        REG_IN_IS_WIDE:  cfg_d.in_is_wide  = cfg_data_i[0];
        REG_OUT_IS_WIDE: cfg_d.out_is_wide = cfg_data_i[0];
        REG_OUT_COUNT:   cfg_d.out_count   = cfg_data_i[OUT_COUNT_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_frac   <= STEP_RESET;
      cfg_q.in_is_wide  <= 1'b1;
      cfg_q.out_is_wide <= 1'b1;
      cfg_q.out_count   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule : asrc_cfg
`default_nettype wire

[rtl/asrc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asrc_ctrl
// Controller: takes one input beat, then issues one output per cycle while
// the datapath has more outputs for this sample and the output is free.
// ----------------------------------------------------------------------------
module asrc_ctrl
  import asrc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status_i.more) begin
          cmd_o.emit = status_i.out_free;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : asrc_ctrl
`default_nettype wire

[rtl/asrc_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asrc_dp
// Datapath: phase accumulator, input and output indexes, sample format
// conversion and the output register.
// ----------------------------------------------------------------------------
module asrc_dp
  import asrc_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cfg_t       cfg_i,
  input  in_item_t   in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output out_item_t  out_data_o
);

  localparam int unsigned SRC_W =
    (COUNT_BITS < PHASE_W - FRAC_BITS) ? COUNT_BITS : PHASE_W - FRAC_BITS;
  localparam int unsigned LAST_W =
    ((COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W) + 1;

  logic [PHASE_W-1:0]    phase_q;
  logic [COUNT_BITS-1:0] in_idx_q;
  logic [COUNT_BITS-1:0] out_idx_q;
  logic [RES_CNT_W-1:0]  res_cnt_q;
  logic [SAMPLE_W-1:0]   smp_q;
  logic [SAMPLE_W-1:0]   smp_d;
  logic [SAMPLE_W-1:0]   src_bits;
  out_item_t             out_q;
  logic                  out_valid_q;

  logic [SRC_W-1:0]      src_idx;
  logic [LAST_W-1:0]     out_idx_x;
  logic [LAST_W-1:0]     out_cnt_x;
  logic                  is_last;

  always_comb begin
    if (cfg_i.in_is_wide) begin
      src_bits = in_data_i.sample_raw;
    end else begin
      src_bits = {in_data_i.sample_raw[7:0] ^ NARROW_BIAS, 8'h00};
    end
    if (cfg_i.out_is_wide) begin
      smp_d = src_bits;
    end else begin
      smp_d = {{8{src_bits[15]}}, src_bits[15:8]};
    end
  end

  assign src_idx   = phase_q[FRAC_BITS +: SRC_W];
  assign out_idx_x = LAST_W'(out_idx_q);
  assign out_cnt_x = LAST_W'(cfg_i.out_count);
  assign is_last   = (out_idx_x + LAST_W'(1)) == out_cnt_x;

  assign status_o.more = (res_cnt_q != RES_CNT_MAX) && (out_idx_x < out_cnt_x) &&
                         (COUNT_BITS'(src_idx) <= in_idx_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      in_idx_q    <= '0;
      out_idx_q   <= '0;
      res_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        res_cnt_q <= '0;
        if (in_data_i.first_sample) begin
          phase_q   <= '0;
          in_idx_q  <= '0;
          out_idx_q <= '0;
        end
      end
      if (cmd_i.emit) begin
        phase_q     <= phase_q + PHASE_W'(cfg_i.step_frac);
        out_idx_q   <= out_idx_q + COUNT_BITS'(1);
        res_cnt_q   <= res_cnt_q + RES_CNT_W'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        in_idx_q <= in_idx_q + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q <= smp_d;
    end
    if (cmd_i.emit) begin
      out_q.out_sample <= smp_q;
      out_q.last_out   <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : asrc_dp
`default_nettype wire

[rtl/audio_sample_rate_converter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// audio_sample_rate_converter
// Nearest-neighbor sample rate converter for one mono sound.
// ----------------------------------------------------------------------------
// Each accepted input beat produces n output beats, n from 0 to 64: the
// controller takes the beat, then emits outputs while the phase
// accumulator's integer part does not pass the input index and the output
// count is not reached, then steps the input index. Output beats leave
// through a single output register; back-pressure on the output holds a
// further output of the same input while the register holds a beat.
// Configuration is to be written through the plain write port only while
// the converter is idle, which the block itself does not enforce; so
// written, it takes effect on the next input beat.
// ----------------------------------------------------------------------------
module audio_sample_rate_converter
  import asrc_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output out_item_t            out_data_o,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  asrc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  asrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  asrc_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule : audio_sample_rate_converter
`default_nettype wire
